/* src/mrde_pkg.sv */
// Package for the mini RISC decode/execute block.
// Holds opcode and funct codes, the status type and the execute control struct.
// No dependencies.
package mrde_pkg;

  localparam int unsigned NUM_REGS = 8;

  localparam logic [3:0] OP_RTYPE = 4'h0;
  localparam logic [3:0] OP_JUMP  = 4'h2;
  localparam logic [3:0] OP_JAL   = 4'h3;
  localparam logic [3:0] OP_ADDI  = 4'h8;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_FUNCT  = 2'd1,
    ST_JUMP       = 2'd2,
    ST_BAD_OPCODE = 2'd3
  } status_t;

  typedef struct packed {
    logic       reg_wr;
    logic [2:0] reg_idx;
    logic       mem_wr;
    status_t    status;
  } exec_ctl_t;

endpackage

/* src/mini_risc_decode_execute.sv */
// Top level of the mini RISC decode/execute block.
// Depends on mrde_pkg, mrde_ram and mrde_exec.
//
// One instruction word is accepted per cycle while results are taken; the register
// file reads rs and rt at acceptance (registered RAM read), the execute stage then
// decodes, runs the ALU and writes back, and the result register holds the item until
// taken. Sustained rate is one item per cycle while results are taken; a stalled result
// holds one more item in the execute stage. A write-back in the cycle an item is read is
// forwarded, and registers never written read as zero through per-entry valid bits.
module mini_risc_decode_execute #(
  parameter int unsigned DATA_WIDTH    = 8,
  parameter int unsigned PROGRAM_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_instruction_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pc_now,
  output logic        out_reg_write,
  output logic [2:0]  out_reg_index,
  output logic [7:0]  out_reg_value,
  output logic        out_mem_write,
  output logic [2:0]  out_mem_address,
  output logic [7:0]  out_mem_value,
  output logic [1:0]  out_status
);

  localparam int unsigned PCW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam logic [PCW-1:0] PC_LAST = PCW'(PROGRAM_DEPTH - 1);
  localparam int unsigned NR = mrde_pkg::NUM_REGS;

  logic                  in_fire;
  logic                  advance;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [15:0]           instr_r;
  logic                  fwd_a_r, fwd_b_r;
  logic [DATA_WIDTH-1:0] fwd_d_r;
  logic                  vld_a_r, vld_b_r;
  logic [NR-1:0]         reg_vld_r;

  logic [DATA_WIDTH-1:0] ram_a, ram_b;
  logic [DATA_WIDTH-1:0] op_a, op_b;
  mrde_pkg::exec_ctl_t   ctl;
  logic [DATA_WIDTH-1:0] value;
  logic                  wr_en;

  logic [PCW-1:0]        pc_fol_r, pc_fol_nxt;
  logic [PCW+7:0]        pc_ext;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            pc_now_r;
  logic                  reg_write_r;
  logic [2:0]            reg_index_r;
  logic [7:0]            reg_value_r;
  logic                  mem_write_r;
  logic [2:0]            mem_address_r;
  logic [7:0]            mem_value_r;
  logic [1:0]            status_r;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = advance && ctl.reg_wr;

  mrde_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NR)) u_rf_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ctl.reg_idx),
    .wdata (value),
    .re    (in_fire),
    .raddr (in_instruction_word[11:9]),
    .rdata (ram_a)
  );

  mrde_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NR)) u_rf_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ctl.reg_idx),
    .wdata (value),
    .re    (in_fire),
    .raddr (in_instruction_word[8:6]),
    .rdata (ram_b)
  );

  assign op_a = fwd_a_r ? fwd_d_r : (vld_a_r ? ram_a : '0);
  assign op_b = fwd_b_r ? fwd_d_r : (vld_b_r ? ram_b : '0);

  mrde_exec #(.DATA_WIDTH(DATA_WIDTH)) u_exec (
    .instr (instr_r),
    .op_a  (op_a),
    .op_b  (op_b),
    .ctl   (ctl),
    .value (value)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    pc_fol_nxt = (pc_fol_r == PC_LAST) ? '0 : pc_fol_r + 1'b1;
    pc_ext     = {8'd0, pc_fol_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      reg_vld_r   <= '0;
      pc_fol_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        reg_vld_r[ctl.reg_idx] <= 1'b1;
      end
      if (advance) begin
        pc_fol_r <= pc_fol_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      instr_r <= in_instruction_word;
      vld_a_r <= reg_vld_r[in_instruction_word[11:9]];
      vld_b_r <= reg_vld_r[in_instruction_word[8:6]];
      fwd_a_r <= wr_en && (ctl.reg_idx == in_instruction_word[11:9]);
      fwd_b_r <= wr_en && (ctl.reg_idx == in_instruction_word[8:6]);
      fwd_d_r <= value;
    end
    if (advance) begin
      pc_now_r      <= pc_ext[7:0];
      reg_write_r   <= ctl.reg_wr;
      reg_index_r   <= ctl.reg_idx;
      reg_value_r   <= value[7:0];
      mem_write_r   <= ctl.mem_wr;
      mem_address_r <= ctl.mem_wr ? ctl.reg_idx : 3'd0;
      mem_value_r   <= ctl.mem_wr ? value[7:0] : 8'd0;
      status_r      <= ctl.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pc_now      = pc_now_r;
  assign out_reg_write   = reg_write_r;
  assign out_reg_index   = reg_index_r;
  assign out_reg_value   = reg_value_r;
  assign out_mem_write   = mem_write_r;
  assign out_mem_address = mem_address_r;
  assign out_mem_value   = mem_value_r;
  assign out_status      = status_r;

endmodule

/* src/mrde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/mrde_exec.sv */
// Decode and ALU for one instruction word.
// Depends on mrde_pkg for opcodes, funct codes and the control struct.
module mrde_exec #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic [15:0]            instr,
  input  logic [DATA_WIDTH-1:0]  op_a,
  input  logic [DATA_WIDTH-1:0]  op_b,
  output mrde_pkg::exec_ctl_t    ctl,
  output logic [DATA_WIDTH-1:0]  value
);

  logic [3:0]            opcode;
  logic [2:0]            rt;
  logic [2:0]            rd;
  logic [2:0]            funct;
  logic [DATA_WIDTH-1:0] imm_ext;

  assign opcode  = instr[15:12];
  assign rt      = instr[8:6];
  assign rd      = instr[5:3];
  assign funct   = instr[2:0];
  assign imm_ext = {{(DATA_WIDTH-6){1'b0}}, instr[5:0]};

  always_comb begin
    ctl.reg_wr  = 1'b0;
    ctl.reg_idx = 3'd0;
    ctl.mem_wr  = 1'b0;
    ctl.status  = mrde_pkg::ST_OK;
    value       = '0;
    case (opcode)
      mrde_pkg::OP_RTYPE: begin
        ctl.reg_wr  = 1'b1;
        ctl.reg_idx = rd;
        case (funct)
          mrde_pkg::FN_ADD: value = op_a + op_b;
          mrde_pkg::FN_SUB: value = op_a - op_b;
          mrde_pkg::FN_AND: value = op_a & op_b;
          mrde_pkg::FN_OR:  value = op_a | op_b;
          default: begin
            ctl.reg_wr  = 1'b0;
            ctl.reg_idx = 3'd0;
            ctl.status  = mrde_pkg::ST_BAD_FUNCT;
          end
        endcase
      end
      mrde_pkg::OP_JUMP, mrde_pkg::OP_JAL: begin
        ctl.status = mrde_pkg::ST_JUMP;
      end
      mrde_pkg::OP_ADDI: begin
        ctl.reg_wr  = 1'b1;
        ctl.reg_idx = rt;
        ctl.mem_wr  = 1'b1;
        value       = op_a + imm_ext;
      end
      default: begin
        ctl.status = mrde_pkg::ST_BAD_OPCODE;
      end
    endcase
  end

endmodule

/* src/mrde_checker.sv */
// Port-level checker for the mini RISC decode/execute block, with its bind.
// Depends on mrde_pkg for status codes.
module mrde_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_pc_now,
  input logic        out_reg_write,
  input logic [2:0]  out_reg_index,
  input logic [7:0]  out_reg_value,
  input logic        out_mem_write,
  input logic [2:0]  out_mem_address,
  input logic [7:0]  out_mem_value,
  input logic [1:0]  out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pc_now) && $stable(out_status))
    else $error("result item dropped or changed while stalled");

  a_mem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_write |-> out_reg_write && (out_mem_address == out_reg_index)
      && (out_mem_value == out_reg_value))
    else $error("data store write does not match register write");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 2'(mrde_pkg::ST_OK)) |-> !out_reg_write && !out_mem_write
      && (out_reg_index == 3'd0) && (out_reg_value == 8'd0))
    else $error("write reported with a failing status");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind mini_risc_decode_execute mrde_checker u_mrde_checker (.*);
